/* hw/rtl/lif_pkg.sv */
// Shared types and constants for the leaky integrate-and-fire neuron.
// Register index codes, register reset values, configuration and result structs.
// No dependencies.
`default_nettype none

package lif_pkg;

   localparam int unsigned POT_W   = 16;
   localparam int unsigned SHIFT_W = 4;
   localparam int unsigned REFR_W  = 8;
   localparam int unsigned INDEX_W = 3;

   typedef enum logic [INDEX_W-1:0] {
      REG_FIRE_THRESHOLD        = 3'd0,
      REG_LEAK_SHIFT            = 3'd1,
      REG_AFTER_SPIKE_POTENTIAL = 3'd2,
      REG_REST_POTENTIAL        = 3'd3,
      REG_REFRACTORY_LENGTH     = 3'd4
   } reg_index_type;

   localparam logic signed [POT_W-1:0] FIRE_THRESHOLD_RST        = 16'sd1024;
   localparam logic [SHIFT_W-1:0]      LEAK_SHIFT_RST            = 4'd3;
   localparam logic signed [POT_W-1:0] AFTER_SPIKE_POTENTIAL_RST = 16'sd0;
   localparam logic signed [POT_W-1:0] REST_POTENTIAL_RST        = 16'sd0;
   localparam logic [REFR_W-1:0]       REFRACTORY_LENGTH_RST     = 8'd4;

   // func codes of an input item
   localparam logic FUNC_STEP  = 1'b0;
   localparam logic FUNC_RESET = 1'b1;

   typedef struct packed {
      logic signed [POT_W-1:0] fire_threshold;
      logic [SHIFT_W-1:0]      leak_shift;
      logic signed [POT_W-1:0] after_spike_potential;
      logic signed [POT_W-1:0] rest_potential;
      logic [REFR_W-1:0]       refractory_length;
   } cfg_type;

   typedef struct packed {
      logic                    spike;
      logic signed [POT_W-1:0] potential;
      logic [REFR_W-1:0]       refractory_left;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/lif_neuron_step.sv */
// Leaky integrate-and-fire neuron, top level: input register, update, result register.
// An accepted req passes the input register, then the result register, to rsp. Throughput
// 1 item per cycle unless rsp stalls; membrane/refractory update feeds back on itself.
// Reset (synchronous, active high) empties both stages, loads register defaults,
// sets the membrane to the default rest potential and clears the refractory count.
// Depends on lif_pkg, lif_csr and lif_core.
`default_nettype none

module lif_neuron_step (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_func,
   input  wire logic signed [lif_pkg::POT_W-1:0]     req_input_current,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_spike,
   output logic signed [lif_pkg::POT_W-1:0]          rsp_potential,
   output logic [lif_pkg::REFR_W-1:0]                rsp_refractory_left,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lif_pkg::INDEX_W-1:0]          csr_index,
   input  wire logic [lif_pkg::POT_W-1:0]            csr_wdata
);

   lif_pkg::cfg_type    cfg;
   lif_pkg::result_type result;

   logic                             in_valid_ff;
   logic                             in_func_ff;
   logic signed [lif_pkg::POT_W-1:0] in_current_ff;
   logic                             out_valid_ff;
   lif_pkg::result_type              out_ff;
   logic signed [lif_pkg::POT_W-1:0] membrane_ff;
   logic [lif_pkg::REFR_W-1:0]       refr_count_ff;

   logic advance;
   logic fire;
   logic req_take;

   assign csr_ready = 1'b1;

   lif_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   lif_core u_core (
      .func        (in_func_ff),
      .syn_current (in_current_ff),
      .membrane    (membrane_ff),
      .refr_count  (refr_count_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // result stage can take a new item when empty or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         membrane_ff   <= lif_pkg::REST_POTENTIAL_RST;
         refr_count_ff <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff  <= 1'b1;
            membrane_ff   <= result.potential;
            refr_count_ff <= result.refractory_left;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff    <= req_func;
         in_current_ff <= req_input_current;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_spike           = out_ff.spike;
   assign rsp_potential       = out_ff.potential;
   assign rsp_refractory_left = out_ff.refractory_left;

endmodule

`default_nettype wire

/* hw/rtl/lif_csr.sv */
// Configuration register file of the neuron.
// Depends on lif_pkg for register codes, reset values and cfg_type.
`default_nettype none

module lif_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [lif_pkg::INDEX_W-1:0]          wr_index,
   input  wire logic [lif_pkg::POT_W-1:0]            wr_data,
   output lif_pkg::cfg_type                         cfg
);

   lif_pkg::cfg_type cfg_ff;
   lif_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            lif_pkg::REG_FIRE_THRESHOLD: begin
               cfg_in.fire_threshold = $signed(wr_data);
            end
            lif_pkg::REG_LEAK_SHIFT: begin
               cfg_in.leak_shift = wr_data[lif_pkg::SHIFT_W-1:0];
            end
            lif_pkg::REG_AFTER_SPIKE_POTENTIAL: begin
               cfg_in.after_spike_potential = $signed(wr_data);
            end
            lif_pkg::REG_REST_POTENTIAL: begin
               cfg_in.rest_potential = $signed(wr_data);
            end
            lif_pkg::REG_REFRACTORY_LENGTH: begin
               cfg_in.refractory_length = wr_data[lif_pkg::REFR_W-1:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_threshold        <= lif_pkg::FIRE_THRESHOLD_RST;
         cfg_ff.leak_shift            <= lif_pkg::LEAK_SHIFT_RST;
         cfg_ff.after_spike_potential <= lif_pkg::AFTER_SPIKE_POTENTIAL_RST;
         cfg_ff.rest_potential        <= lif_pkg::REST_POTENTIAL_RST;
         cfg_ff.refractory_length     <= lif_pkg::REFRACTORY_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/lif_core.sv */
// Combinational neuron update: integrate, leak, spike check, refractory count.
// Depends on lif_pkg for cfg_type, result_type and func codes.
`default_nettype none

module lif_core (
   input  wire logic                                func,
   input  wire logic signed [lif_pkg::POT_W-1:0]     syn_current,
   input  wire logic signed [lif_pkg::POT_W-1:0]     membrane,
   input  wire logic [lif_pkg::REFR_W-1:0]           refr_count,
   input  wire lif_pkg::cfg_type                    cfg,
   output lif_pkg::result_type                      result
);

   logic signed [lif_pkg::POT_W-1:0] sum;
   logic [lif_pkg::POT_W:0]          delta;
   logic [lif_pkg::POT_W:0]          mag;
   logic [lif_pkg::POT_W:0]          mag_shr;
   logic [lif_pkg::POT_W-1:0]        leak;
   logic signed [lif_pkg::POT_W-1:0] decayed;

   always_comb begin
      sum   = membrane + syn_current;
      delta = {sum[lif_pkg::POT_W-1], sum} -
              {cfg.rest_potential[lif_pkg::POT_W-1], cfg.rest_potential};
      mag     = delta[lif_pkg::POT_W] ? (~delta + 1'b1) : delta;
      mag_shr = mag >> cfg.leak_shift;
      // truncation toward zero: shift the magnitude, then restore the sign
      leak = delta[lif_pkg::POT_W] ? (~mag_shr[lif_pkg::POT_W-1:0] + 1'b1)
                                   : mag_shr[lif_pkg::POT_W-1:0];
      decayed = $signed(sum - leak);

      result = '0;
      if (func == lif_pkg::FUNC_RESET) begin
         result.potential       = cfg.rest_potential;
         result.refractory_left = '0;
      end else if (refr_count != '0) begin
         result.potential       = membrane;
         result.refractory_left = refr_count - 1'b1;
      end else if (decayed >= cfg.fire_threshold) begin
         result.spike           = 1'b1;
         result.potential       = cfg.after_spike_potential;
         result.refractory_left = cfg.refractory_length;
      end else begin
         result.potential       = decayed;
         result.refractory_left = '0;
      end
   end

endmodule

`default_nettype wire

/* verif/lif_spike_check.sv */
// Checker for lif_neuron_step: follows the csr, req and rsp handshakes, keeps its own
// copy of the neuron settings and state, and compares every rsp item with the predicted one.
// Depends on lif_pkg.

module lif_spike_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_func,
   input  logic signed [lif_pkg::POT_W-1:0] req_input_current,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_spike,
   input  logic signed [lif_pkg::POT_W-1:0] rsp_potential,
   input  logic [lif_pkg::REFR_W-1:0]       rsp_refractory_left,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [lif_pkg::INDEX_W-1:0]      csr_index,
   input  logic [lif_pkg::POT_W-1:0]        csr_wdata,
   output int                               mismatches,
   output int                               awaiting
);

   lif_pkg::cfg_type                 settings;
   logic signed [lif_pkg::POT_W-1:0] membrane;
   logic [lif_pkg::REFR_W-1:0]       refr_count;
   lif_pkg::result_type              neuron_outputs_due[$];
   int                               fail_tally = 0;

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   function automatic void note_field(string field, int expected, int actual);
      fail_tally++;
      if (fail_tally <= 10)
         $display("lif_spike_check: %0t %s expected %0d got %0d", $time, field, expected,
                  actual);
   endfunction

   always @(posedge clock) begin : track
      lif_pkg::result_type              want;
      logic signed [lif_pkg::POT_W-1:0] summed;
      int                               gap;
      int                               drop;
      if (reset) begin
         settings = '{fire_threshold:        lif_pkg::FIRE_THRESHOLD_RST,
                      leak_shift:            lif_pkg::LEAK_SHIFT_RST,
                      after_spike_potential: lif_pkg::AFTER_SPIKE_POTENTIAL_RST,
                      rest_potential:        lif_pkg::REST_POTENTIAL_RST,
                      refractory_length:     lif_pkg::REFRACTORY_LENGTH_RST};
         membrane   = lif_pkg::REST_POTENTIAL_RST;
         refr_count = '0;
         neuron_outputs_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (neuron_outputs_due.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("lif_spike_check: %0t result item with none outstanding", $time);
            end else begin
               want = neuron_outputs_due.pop_front();
               if (rsp_spike !== want.spike)
                  note_field("spike", want.spike, rsp_spike);
               if (rsp_potential !== want.potential)
                  note_field("potential", int'($signed(want.potential)),
                             int'($signed(rsp_potential)));
               if (rsp_refractory_left !== want.refractory_left)
                  note_field("refractory_left", want.refractory_left, rsp_refractory_left);
            end
         end

         if (csr_valid && csr_ready) begin
            // indexes past the register list are dropped
            case (csr_index)
               lif_pkg::REG_FIRE_THRESHOLD:
                  settings.fire_threshold = csr_wdata;
               lif_pkg::REG_LEAK_SHIFT:
                  settings.leak_shift = csr_wdata[lif_pkg::SHIFT_W-1:0];
               lif_pkg::REG_AFTER_SPIKE_POTENTIAL:
                  settings.after_spike_potential = csr_wdata;
               lif_pkg::REG_REST_POTENTIAL:
                  settings.rest_potential = csr_wdata;
               lif_pkg::REG_REFRACTORY_LENGTH:
                  settings.refractory_length = csr_wdata[lif_pkg::REFR_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want.spike = 1'b0;
            if (req_func == lif_pkg::FUNC_RESET) begin
               membrane   = settings.rest_potential;
               refr_count = '0;
            end else begin
               // integrate and leak only outside the refractory window
               if (refr_count == 0) begin
                  summed = membrane + req_input_current;
                  gap    = int'($signed(summed)) - int'($signed(settings.rest_potential));
                  drop   = (gap < 0 ? -gap : gap) >> settings.leak_shift;
                  if (gap < 0)
                     drop = -drop;
                  membrane = lif_pkg::POT_W'(int'($signed(summed)) - drop);
               end
               if (refr_count != 0) begin
                  refr_count = refr_count - 1'b1;
               end else if ($signed(membrane) >= $signed(settings.fire_threshold)) begin
                  want.spike = 1'b1;
                  refr_count = settings.refractory_length;
                  membrane   = settings.after_spike_potential;
               end
            end
            want.potential       = membrane;
            want.refractory_left = refr_count;
            neuron_outputs_due.push_back(want);
         end
      end
      awaiting   <= neuron_outputs_due.size();
      mismatches <= fail_tally;
   end

endmodule

/* verif/tb_top.sv */
// Top of the lif_neuron_step testbench: clock, reset, settings writes, step and reset
// items with random pacing on both channels, watchdog and verdict.
// Depends on lif_pkg, lif_neuron_step and lif_spike_check.

module tb_top;

   localparam int QUIET_LIMIT = 2000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_func = lif_pkg::FUNC_STEP;
   logic signed [lif_pkg::POT_W-1:0] req_input_current = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b1;
   logic                             rsp_spike;
   logic signed [lif_pkg::POT_W-1:0] rsp_potential;
   logic [lif_pkg::REFR_W-1:0]       rsp_refractory_left;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lif_pkg::INDEX_W-1:0]      csr_index = '0;
   logic [lif_pkg::POT_W-1:0]        csr_wdata = '0;

   int   mismatches;
   int   awaiting;
   bit   pace_on = 1'b1;
   int   stall_left = 0;
   int   quiet_cycles = 0;

   always #6 clock = ~clock;

   lif_neuron_step dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_input_current   (req_input_current),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_spike           (rsp_spike),
      .rsp_potential       (rsp_potential),
      .rsp_refractory_left (rsp_refractory_left),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   lif_spike_check checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_input_current   (req_input_current),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_spike           (rsp_spike),
      .rsp_potential       (rsp_potential),
      .rsp_refractory_left (rsp_refractory_left),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .awaiting            (awaiting)
   );

   // result side back-pressure: random bursts of stalled cycles
   always @(posedge clock) begin
      if (reset || !pace_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_item(input logic func, input logic [lif_pkg::POT_W-1:0] current);
      req_valid         <= 1'b1;
      req_func          <= func;
      req_input_current <= current;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (pace_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_reg(input logic [lif_pkg::INDEX_W-1:0] index,
                            input logic [lif_pkg::POT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // junk in the unused upper bits of the narrow registers, plus a write to a dead index
   task automatic load_settings(input logic [lif_pkg::POT_W-1:0] thr,
                                input logic [lif_pkg::SHIFT_W-1:0] leak,
                                input logic [lif_pkg::POT_W-1:0] after,
                                input logic [lif_pkg::POT_W-1:0] rest,
                                input logic [lif_pkg::REFR_W-1:0] refr);
      wait_drained();
      write_reg(lif_pkg::REG_FIRE_THRESHOLD, thr);
      write_reg(lif_pkg::REG_LEAK_SHIFT,
                (16'($urandom) & 16'hFFF0) | lif_pkg::POT_W'(leak));
      write_reg(lif_pkg::REG_AFTER_SPIKE_POTENTIAL, after);
      write_reg(lif_pkg::INDEX_W'($urandom_range(lif_pkg::REG_REFRACTORY_LENGTH + 1,
                                                 2**lif_pkg::INDEX_W - 1)),
                16'($urandom));
      write_reg(lif_pkg::REG_REST_POTENTIAL, rest);
      write_reg(lif_pkg::REG_REFRACTORY_LENGTH, {8'($urandom), refr});
      csr_valid <= 1'b0;
   endtask

   task automatic pick_settings();
      logic [lif_pkg::POT_W-1:0]  thr;
      logic [lif_pkg::POT_W-1:0]  after;
      logic [lif_pkg::POT_W-1:0]  rest;
      logic [lif_pkg::REFR_W-1:0] refr;
      case ($urandom_range(0, 9))
         0:       thr = 16'h8000;
         1:       thr = 16'h7FFF;
         default: thr = 16'($urandom_range(100, 4000));
      endcase
      after = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                          : 16'(int'($urandom_range(0, 2500)) - 2000);
      rest  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'(int'($urandom_range(0, 1000)) - 500);
      refr  = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(7, 255))
                                           : 8'($urandom_range(0, 6));
      load_settings(thr, 4'($urandom_range(0, 15)), after, rest, refr);
   endtask

   task automatic random_steps(input int count);
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 19);
         if (kind == 0)
            send_item(lif_pkg::FUNC_RESET, 16'($urandom));
         else if (kind < 5)
            send_item(lif_pkg::FUNC_STEP, 16'($urandom));
         else if (kind == 5)
            send_item(lif_pkg::FUNC_STEP, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
         else
            // small drive so the membrane climbs to threshold over a few steps
            send_item(lif_pkg::FUNC_STEP, 16'(int'($urandom_range(0, 800)) - 200));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // power-on settings: fire, ride out the refractory window, wrap both ways
      send_item(lif_pkg::FUNC_RESET, 16'h7FFF);
      send_item(lif_pkg::FUNC_STEP, 16'h0000);
      send_item(lif_pkg::FUNC_STEP, 16'h7FFF);
      repeat (4) send_item(lif_pkg::FUNC_STEP, 16'h8000);
      send_item(lif_pkg::FUNC_STEP, 16'h8000);
      send_item(lif_pkg::FUNC_STEP, 16'h8000);
      send_item(lif_pkg::FUNC_STEP, 16'h5555);
      send_item(lif_pkg::FUNC_STEP, 16'hAAAA);

      // lowest threshold, zero refractory length: fires and integrates on every step
      load_settings(16'h8000, 4'd15, 16'h7FFF, 16'h8000, 8'd0);
      send_item(lif_pkg::FUNC_STEP, 16'h0001);
      send_item(lif_pkg::FUNC_STEP, 16'h7FFF);
      send_item(lif_pkg::FUNC_STEP, 16'h0000);
      send_item(lif_pkg::FUNC_RESET, 16'h8000);

      // no leak divisor: membrane snaps to rest, which sits at the top threshold
      load_settings(16'h7FFF, 4'd0, 16'h0000, 16'h7FFF, 8'd255);
      send_item(lif_pkg::FUNC_STEP, 16'h8000);
      repeat (3) send_item(lif_pkg::FUNC_STEP, 16'h7FFF);
      send_item(lif_pkg::FUNC_RESET, 16'h1234);
      send_item(lif_pkg::FUNC_STEP, 16'h0064);

      // moving rest alone leaves the membrane until the next leak or reset item
      wait_drained();
      write_reg(lif_pkg::REG_REST_POTENTIAL, 16'hFC18);
      csr_valid <= 1'b0;
      send_item(lif_pkg::FUNC_STEP, 16'h0010);
      send_item(lif_pkg::FUNC_RESET, 16'h0000);

      for (int phase = 0; phase < 8; phase++) begin
         pace_on = (phase == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
         pick_settings();
         random_steps(60);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
